// ===== src/rcnd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcnd_pkg
// Shared constants, request codes and inter-module types for the ring
// cursor next-mark distance block.
// ----------------------------------------------------------------------------
package rcnd_pkg;

  localparam int MAX_POS   = 4096;
  localparam int IDX_W     = $clog2(MAX_POS);
  localparam int SIZE_W    = 13;
  localparam int STEP_W    = 32;
  localparam int DIST_W    = 12;
  localparam int REQ_W     = 2;

  // Mark store organisation: rows of WORD_W mark bits
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ROWS      = MAX_POS / WORD_W;
  localparam int ROW_W     = $clog2(ROWS);

  // Modulo unit retires two dividend bits per cycle
  localparam int MOD_CYCLES = STEP_W / 2;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  localparam logic [REQ_W-1:0] REQ_TOGGLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    word_t            wr_data;
  } store_req_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

endpackage

// ===== src/rcnd_mark_store.sv =====
// ----------------------------------------------------------------------------
// rcnd_mark_store
// Mark bit memory, one row of rcnd_pkg::WORD_W marks per address, with a
// registered read and per-row valid flags so that unwritten rows read zero.
// ----------------------------------------------------------------------------
module rcnd_mark_store (
  input  logic                clk,
  input  logic                rst_n,
  input  rcnd_pkg::store_req_t req,
  output rcnd_pkg::word_t     rd_data
);

  rcnd_pkg::word_t            mem [rcnd_pkg::ROWS];
  rcnd_pkg::word_t            rd_word_r;
  logic [rcnd_pkg::ROWS-1:0]  row_vld_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_row];
      end
    end
  end

  // A row never written since reset reads as all cleared
  assign rd_data = rd_vld_r ? rd_word_r : '0;

`ifndef SYNTHESIS
  a_no_same_row_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr_en && req.rd_en && (req.wr_row == req.rd_row)))
    else $error("mark store read and write hit the same row");
`endif

endmodule

// ===== src/rcnd_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rcnd_mod_unit
// Iterative restoring remainder: dividend modulo divisor, two dividend bits
// per cycle, result valid with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rcnd_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcnd_pkg::mod_req_t            req,
  output logic                          done,
  output logic [rcnd_pkg::SIZE_W-1:0]   remainder
);

  logic [rcnd_pkg::STEP_W-1:0]    dvd_r;
  logic [rcnd_pkg::SIZE_W-1:0]    div_r;
  logic [rcnd_pkg::SIZE_W-1:0]    rem_r;
  logic [rcnd_pkg::SIZE_W-1:0]    rem_nxt;
  logic [rcnd_pkg::MOD_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [rcnd_pkg::SIZE_W:0]      r_a;
  logic [rcnd_pkg::SIZE_W:0]      r_b;

  always_comb begin
    r_a = {rem_r, dvd_r[rcnd_pkg::STEP_W-1]};
    if (r_a >= {1'b0, div_r}) begin
      r_a = r_a - {1'b0, div_r};
    end
    r_b = {r_a[rcnd_pkg::SIZE_W-1:0], dvd_r[rcnd_pkg::STEP_W-2]};
    if (r_b >= {1'b0, div_r}) begin
      r_b = r_b - {1'b0, div_r};
    end
    rem_nxt = r_b[rcnd_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[rcnd_pkg::STEP_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rcnd_pkg::MOD_CNT_W'(rcnd_pkg::MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("modulo unit restarted while busy");
`endif

endmodule

// ===== src/ring_cursor_next_mark_distance.sv =====
// ----------------------------------------------------------------------------
// ring_cursor_next_mark_distance
// Ring of marks with a cursor: toggle a mark, advance the cursor, or ask the
// clockwise distance from the cursor to the nearest mark.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per transfer. Toggle
//   and advance give no result; a query gives one result transfer on the
//   out_ channel (out_valid / out_stall). Request code 3 is dropped.
//   Configuration (cfg_valid / cfg_ready) writes ring_size; 0 is taken as 1,
//   values above 4096 saturate. The cursor is then reduced modulo the new
//   size, with cfg_ready low and in_stall high meanwhile.
// Handling, one request at a time:
//   toggle  read, modify, write back one row of 64 marks
//   advance step count reduced in the 2-bit-per-cycle modulo unit
//   query   scans R rows of 64 marks (at most 65, one read port); the
//           result then passes to the output register.
//   A finished result sits in the output register until taken; new requests
//   are still accepted meanwhile, but a further query waits there for the
//   output register to drain.
// Reset: marks all cleared (per-row valid flags, no clearing pass), cursor
//   at position one, ring_size 4096. Usable in the cycle after reset.
// ----------------------------------------------------------------------------
module ring_cursor_next_mark_distance (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rcnd_pkg::REQ_W-1:0]    in_req_type,
  input  logic [rcnd_pkg::SIZE_W-1:0]   in_position,
  input  logic [rcnd_pkg::STEP_W-1:0]   in_step_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rcnd_pkg::DIST_W-1:0]   out_distance,
  output logic                          out_none_marked,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcnd_pkg::SIZE_W-1:0]   cfg_ring_size
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TGL  = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [rcnd_pkg::SIZE_W-1:0]    size_r, size_nxt;
  logic [rcnd_pkg::IDX_W-1:0]     cursor_r, cursor_nxt;
  logic                           mod_cfg_r, mod_cfg_nxt;
  logic [rcnd_pkg::ROW_W-1:0]     tgl_row_r, tgl_row_nxt;
  logic [rcnd_pkg::BIT_W-1:0]     tgl_bit_r, tgl_bit_nxt;
  logic                           issue_r, issue_nxt;
  logic [rcnd_pkg::ROW_W-1:0]     scan_row_r, scan_row_nxt;
  logic                           scan_ph_r, scan_ph_nxt;
  logic                           pipe_vld_r, pipe_vld_nxt;
  logic [rcnd_pkg::ROW_W-1:0]     pipe_row_r, pipe_row_nxt;
  logic                           pipe_ph_r, pipe_ph_nxt;
  logic                           pipe_last_r, pipe_last_nxt;
  logic [rcnd_pkg::DIST_W-1:0]    res_dist_r, res_dist_nxt;
  logic                           res_none_r, res_none_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [rcnd_pkg::DIST_W-1:0]    out_dist_r, out_dist_nxt;
  logic                           out_none_r, out_none_nxt;

  logic                           in_accept, cfg_accept;
  logic [rcnd_pkg::SIZE_W-1:0]    cfg_sat;
  logic [rcnd_pkg::SIZE_W-1:0]    pos_m1;
  logic [rcnd_pkg::IDX_W-1:0]     last_idx;
  logic [rcnd_pkg::ROW_W-1:0]     cur_row, last_row;
  logic                           issue_last;
  logic [rcnd_pkg::SIZE_W-1:0]    adv_sum;
  rcnd_pkg::store_req_t           st_req;
  rcnd_pkg::word_t                rd_data;
  rcnd_pkg::mod_req_t             mod_req;
  logic                           mod_done;
  logic [rcnd_pkg::SIZE_W-1:0]    mod_rem;
  rcnd_pkg::word_t                ge_c, le_l, mask, hits;
  logic [rcnd_pkg::BIT_W-1:0]     enc;
  logic [rcnd_pkg::IDX_W-1:0]     hit_idx;
  logic [rcnd_pkg::SIZE_W-1:0]    dist_wide;

  rcnd_mark_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (rd_data)
  );

  rcnd_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mod_req),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign cfg_ready  = (state_r == ST_IDLE);
  assign cfg_accept = cfg_valid && cfg_ready;
  assign in_stall   = (state_r != ST_IDLE) || cfg_valid;
  assign in_accept  = in_valid && !in_stall;

  always_comb begin
    cfg_sat = cfg_ring_size;
    if (cfg_ring_size == '0) begin
      cfg_sat = rcnd_pkg::SIZE_W'(1);
    end else if (cfg_ring_size > rcnd_pkg::SIZE_W'(rcnd_pkg::MAX_POS)) begin
      cfg_sat = rcnd_pkg::SIZE_W'(rcnd_pkg::MAX_POS);
    end
  end

  assign pos_m1   = in_position - 1'b1;
  assign last_idx = rcnd_pkg::IDX_W'(size_r - 1'b1);
  assign cur_row  = cursor_r[rcnd_pkg::IDX_W-1:rcnd_pkg::BIT_W];
  assign last_row = last_idx[rcnd_pkg::IDX_W-1:rcnd_pkg::BIT_W];

  // First pass runs from the cursor row to the last row in use, second pass
  // wraps from row zero back to the cursor row.
  assign issue_last = scan_ph_r && (scan_row_r == cur_row);

  assign adv_sum = {1'b0, cursor_r} + mod_rem;

  // Hit mask for the row in the evaluate stage
  always_comb begin
    if (pipe_row_r > cur_row) begin
      ge_c = '1;
    end else if (pipe_row_r < cur_row) begin
      ge_c = '0;
    end else begin
      ge_c = rcnd_pkg::word_t'('1) << cursor_r[rcnd_pkg::BIT_W-1:0];
    end
    if (pipe_row_r < last_row) begin
      le_l = '1;
    end else if (pipe_row_r > last_row) begin
      le_l = '0;
    end else begin
      le_l = rcnd_pkg::word_t'('1) >>
             (rcnd_pkg::BIT_W'(rcnd_pkg::WORD_W - 1) - last_idx[rcnd_pkg::BIT_W-1:0]);
    end
    mask = pipe_ph_r ? ~ge_c : (ge_c & le_l);
    hits = rd_data & mask;
  end

  // Lowest marked bit of the row
  always_comb begin
    enc = '0;
    for (int i = rcnd_pkg::WORD_W - 1; i >= 0; i--) begin
      if (hits[i]) begin
        enc = rcnd_pkg::BIT_W'(i);
      end
    end
  end

  assign hit_idx = {pipe_row_r, enc};

  always_comb begin
    if (pipe_ph_r) begin
      dist_wide = {1'b0, hit_idx} + size_r - {1'b0, cursor_r};
    end else begin
      dist_wide = {1'b0, hit_idx} - {1'b0, cursor_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    cursor_nxt    = cursor_r;
    mod_cfg_nxt   = mod_cfg_r;
    tgl_row_nxt   = tgl_row_r;
    tgl_bit_nxt   = tgl_bit_r;
    issue_nxt     = issue_r;
    scan_row_nxt  = scan_row_r;
    scan_ph_nxt   = scan_ph_r;
    pipe_vld_nxt  = 1'b0;
    pipe_row_nxt  = scan_row_r;
    pipe_ph_nxt   = scan_ph_r;
    pipe_last_nxt = issue_last;
    res_dist_nxt  = res_dist_r;
    res_none_nxt  = res_none_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_none_nxt  = out_none_r;

    st_req          = '0;
    mod_req         = '0;
    mod_req.divisor = size_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_accept) begin
          size_nxt         = cfg_sat;
          mod_req.start    = 1'b1;
          mod_req.dividend = rcnd_pkg::STEP_W'(cursor_r);
          mod_req.divisor  = cfg_sat;
          mod_cfg_nxt      = 1'b1;
          state_nxt        = ST_MOD;
        end else if (in_accept) begin
          unique case (in_req_type)
            rcnd_pkg::REQ_TOGGLE: begin
              if ((in_position != '0) && (in_position <= size_r)) begin
                tgl_row_nxt   = pos_m1[rcnd_pkg::IDX_W-1:rcnd_pkg::BIT_W];
                tgl_bit_nxt   = pos_m1[rcnd_pkg::BIT_W-1:0];
                st_req.rd_en  = 1'b1;
                st_req.rd_row = pos_m1[rcnd_pkg::IDX_W-1:rcnd_pkg::BIT_W];
                state_nxt     = ST_TGL;
              end
            end
            rcnd_pkg::REQ_ADVANCE: begin
              mod_req.start    = 1'b1;
              mod_req.dividend = in_step_count;
              mod_cfg_nxt      = 1'b0;
              state_nxt        = ST_MOD;
            end
            rcnd_pkg::REQ_QUERY: begin
              issue_nxt    = 1'b1;
              scan_row_nxt = cur_row;
              scan_ph_nxt  = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: begin
              // unused code: drop
            end
          endcase
        end
      end
      ST_TGL: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_row  = tgl_row_r;
        st_req.wr_data = rd_data ^ (rcnd_pkg::word_t'(1) << tgl_bit_r);
        state_nxt      = ST_IDLE;
      end
      ST_MOD: begin
        if (mod_done) begin
          if (mod_cfg_r) begin
            cursor_nxt = mod_rem[rcnd_pkg::IDX_W-1:0];
          end else if (adv_sum >= size_r) begin
            cursor_nxt = rcnd_pkg::IDX_W'(adv_sum - size_r);
          end else begin
            cursor_nxt = adv_sum[rcnd_pkg::IDX_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          st_req.rd_en  = 1'b1;
          st_req.rd_row = scan_row_r;
          pipe_vld_nxt  = 1'b1;
          issue_nxt     = !issue_last;
          if (!scan_ph_r && (scan_row_r == last_row)) begin
            scan_row_nxt = '0;
            scan_ph_nxt  = 1'b1;
          end else begin
            scan_row_nxt = scan_row_r + 1'b1;
          end
        end
        if (pipe_vld_r) begin
          if (hits != '0) begin
            res_dist_nxt = dist_wide[rcnd_pkg::DIST_W-1:0];
            res_none_nxt = 1'b0;
            issue_nxt    = 1'b0;
            pipe_vld_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end else if (pipe_last_r) begin
            res_dist_nxt = '0;
            res_none_nxt = 1'b1;
            issue_nxt    = 1'b0;
            pipe_vld_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_none_nxt  = res_none_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= rcnd_pkg::SIZE_W'(rcnd_pkg::MAX_POS);
      cursor_r    <= '0;
      mod_cfg_r   <= 1'b0;
      issue_r     <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      cursor_r    <= cursor_nxt;
      mod_cfg_r   <= mod_cfg_nxt;
      issue_r     <= issue_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgl_row_r   <= tgl_row_nxt;
    tgl_bit_r   <= tgl_bit_nxt;
    scan_row_r  <= scan_row_nxt;
    scan_ph_r   <= scan_ph_nxt;
    pipe_row_r  <= pipe_row_nxt;
    pipe_ph_r   <= pipe_ph_nxt;
    pipe_last_r <= pipe_last_nxt;
    res_dist_r  <= res_dist_nxt;
    res_none_r  <= res_none_nxt;
    out_dist_r  <= out_dist_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_distance    = out_dist_r;
  assign out_none_marked = out_none_r;

`ifndef SYNTHESIS
  a_cursor_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ({1'b0, cursor_r} < size_r))
    else $error("cursor outside the ring while idle");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r != '0) && (size_r <= rcnd_pkg::SIZE_W'(rcnd_pkg::MAX_POS)))
    else $error("ring size out of range");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_MOD))
    else $error("modulo result outside the modulo wait");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_vld_r |-> (state_r == ST_SCAN))
    else $error("scan data pending outside a scan");
`endif

endmodule
